// ===== hw/rtl/ipv4cks_pkg.sv =====
package ipv4cks_pkg;

    localparam logic [15:0] OFFSET_MAX     = 16'hffff;
    localparam logic [15:0] OFS_TOTLEN_HI  = 16'd2;
    localparam logic [15:0] OFS_TOTLEN_LO  = 16'd3;
    localparam logic [15:0] OFS_IPCKS_HI   = 16'd10;
    localparam logic [15:0] OFS_IPCKS_LO   = 16'd11;
    localparam logic [15:0] OFS_ADDR_FIRST = 16'd12;
    localparam logic [15:0] OFS_ADDR_LAST  = 16'd19;
    localparam logic [15:0] SEG_TCPCKS_HI  = 16'd16;
    localparam logic [15:0] SEG_TCPCKS_LO  = 16'd17;
    localparam logic [31:0] TCP_PROTOCOL   = 32'd6;

    typedef struct packed {
        logic [7:0] packet_byte;
        logic       last_byte;
    } t_in;

    typedef struct packed {
        logic [15:0] ip_header_checksum;
        logic [15:0] tcp_checksum;
        logic        packet_short;
    } t_out;

    typedef struct packed {
        logic [31:0] header_sum;
        logic [31:0] segment_sum;
        logic [15:0] seg_len;
        logic        packet_short;
    } t_fin;

endpackage

// ===== hw/rtl/ipv4_tcp_checksum_fixer.sv =====
// IPv4/TCP checksum calculator, one packet byte per transaction.
// The input channel (i_in_valid, o_in_stall, i_in_data) carries the packet in
// wire order, starting at the first IP header byte; last_byte marks the end.
// The output channel (o_out_valid, i_out_stall, o_out_data) carries one
// transaction per packet with the IP header checksum, the TCP checksum and
// a flag that is set when the packet ended before its total length or its header length, whichever is larger.
// A byte is taken in every cycle unless a last byte is held as described
// below. A packet's result passes the input register and the sum register
// ahead of the fold and output register.
// Bytes that are not the last keep flowing while a result waits; only a last
// byte waits for room in the two result registers, so up to two results may
// be pending while the receiver stalls before the input side stalls.
// A synchronous active-low reset empties the pipeline and clears the running
// sums and the byte offset; the state clears again after every last byte.
module ipv4_tcp_checksum_fixer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  ipv4cks_pkg::t_in   i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output ipv4cks_pkg::t_out  o_out_data
);

    logic              r_in_valid;
    ipv4cks_pkg::t_in  r_in_data;
    logic              take;
    logic              in_free;
    logic              fin_valid;
    logic              fin_ready;
    ipv4cks_pkg::t_fin fin;

    assign in_free    = !r_in_valid || take;
    assign o_in_stall = !in_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_free) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_free && i_in_valid) begin
            r_in_data <= i_in_data;
        end
    end

    ipv4cks_accum u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_in_valid),
        .i_data      (r_in_data),
        .o_take      (take),
        .i_fin_ready (fin_ready),
        .o_fin_valid (fin_valid),
        .o_fin       (fin)
    );

    ipv4cks_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fin_valid (fin_valid),
        .i_fin       (fin),
        .o_fin_ready (fin_ready),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== hw/rtl/ipv4cks_accum.sv =====
module ipv4cks_accum (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  ipv4cks_pkg::t_in   i_data,
    output logic               o_take,
    input  logic               i_fin_ready,
    output logic               o_fin_valid,
    output ipv4cks_pkg::t_fin  o_fin
);

    logic [15:0] r_offset;
    logic [5:0]  r_hdr_len;
    logic [15:0] r_tot_len;
    logic [31:0] r_hdr_sum;
    logic [31:0] r_seg_sum;
    logic        r_fin_valid;
    ipv4cks_pkg::t_fin r_fin;

    logic [5:0]  n_hdr_len;
    logic [15:0] n_tot_len;
    logic [31:0] n_hdr_sum;
    logic [31:0] n_seg_sum;
    logic [15:0] hdr_len_ext;
    logic [15:0] seg_ofs;
    logic [15:0] word_val;
    logic        past_hdr;
    logic        zero_byte;
    logic        in_header;
    logic        in_segment;
    logic        is_addr;
    logic        fin_free;
    logic        take;
    logic [15:0] seg_len;
    logic [16:0] count;
    logic [16:0] limit;

    always_comb begin
        n_hdr_len = r_hdr_len;
        n_tot_len = r_tot_len;
        if (r_offset == 16'd0) begin
            n_hdr_len = {i_data.packet_byte[3:0], 2'b00};
        end else if (r_offset == ipv4cks_pkg::OFS_TOTLEN_HI) begin
            n_tot_len = {i_data.packet_byte, r_tot_len[7:0]};
        end else if (r_offset == ipv4cks_pkg::OFS_TOTLEN_LO) begin
            n_tot_len = {r_tot_len[15:8], i_data.packet_byte};
        end
        hdr_len_ext = {10'd0, n_hdr_len};
        past_hdr    = r_offset >= hdr_len_ext;
        seg_ofs     = r_offset - hdr_len_ext;
        zero_byte   = (r_offset == ipv4cks_pkg::OFS_IPCKS_HI)
                   || (r_offset == ipv4cks_pkg::OFS_IPCKS_LO)
                   || (past_hdr && ((seg_ofs == ipv4cks_pkg::SEG_TCPCKS_HI)
                                 || (seg_ofs == ipv4cks_pkg::SEG_TCPCKS_LO)));
        if (zero_byte) begin
            word_val = 16'd0;
        end else if (r_offset[0]) begin
            word_val = {8'd0, i_data.packet_byte};
        end else begin
            word_val = {i_data.packet_byte, 8'd0};
        end
        in_header  = !past_hdr;
        in_segment = past_hdr && (r_offset < n_tot_len);
        is_addr    = (r_offset >= ipv4cks_pkg::OFS_ADDR_FIRST)
                  && (r_offset <= ipv4cks_pkg::OFS_ADDR_LAST);
        n_hdr_sum  = r_hdr_sum + (in_header ? {16'd0, word_val} : 32'd0);
        n_seg_sum  = r_seg_sum + ((in_segment || is_addr) ? {16'd0, word_val} : 32'd0);
        seg_len    = (n_tot_len >= hdr_len_ext) ? (n_tot_len - hdr_len_ext) : 16'd0;
        count      = {1'b0, r_offset} + 17'd1;
        limit      = (n_tot_len > hdr_len_ext) ? {1'b0, n_tot_len} : {1'b0, hdr_len_ext};
    end

    assign fin_free = !r_fin_valid || i_fin_ready;
    assign take     = i_valid && (!i_data.last_byte || fin_free);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset    <= 16'd0;
            r_hdr_len   <= 6'd0;
            r_tot_len   <= 16'd0;
            r_hdr_sum   <= 32'd0;
            r_seg_sum   <= 32'd0;
            r_fin_valid <= 1'b0;
        end else begin
            if (take) begin
                if (i_data.last_byte) begin
                    r_offset  <= 16'd0;
                    r_hdr_len <= 6'd0;
                    r_tot_len <= 16'd0;
                    r_hdr_sum <= 32'd0;
                    r_seg_sum <= 32'd0;
                end else begin
                    if (r_offset != ipv4cks_pkg::OFFSET_MAX) begin
                        r_offset <= r_offset + 16'd1;
                    end
                    r_hdr_len <= n_hdr_len;
                    r_tot_len <= n_tot_len;
                    r_hdr_sum <= n_hdr_sum;
                    r_seg_sum <= n_seg_sum;
                end
            end
            if (take && i_data.last_byte) begin
                r_fin_valid <= 1'b1;
            end else if (i_fin_ready) begin
                r_fin_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && i_data.last_byte) begin
            r_fin.header_sum   <= n_hdr_sum;
            r_fin.segment_sum  <= n_seg_sum;
            r_fin.seg_len      <= seg_len;
            r_fin.packet_short <= count < limit;
        end
    end

    assign o_take      = take;
    assign o_fin_valid = r_fin_valid;
    assign o_fin       = r_fin;

`ifndef ASSERT_OFF
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && i_data.last_byte |=> r_offset == 16'd0 && r_hdr_sum == 32'd0
                                     && r_seg_sum == 32'd0)
        else $error("State not cleared after the last byte.");
    a_fin_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin_valid && !i_fin_ready |=> r_fin_valid && $stable(r_fin))
        else $error("Pending result lost or changed while blocked.");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin_valid && !i_fin_ready |-> !(take && i_data.last_byte))
        else $error("Last byte taken while the result register is blocked.");
    a_offset_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_offset == ipv4cks_pkg::OFFSET_MAX && take && !i_data.last_byte
        |=> r_offset == ipv4cks_pkg::OFFSET_MAX)
        else $error("Byte offset wrapped past saturation.");
`endif

endmodule

// ===== hw/rtl/ipv4cks_out.sv =====
module ipv4cks_out (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fin_valid,
    input  ipv4cks_pkg::t_fin  i_fin,
    output logic               o_fin_ready,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output ipv4cks_pkg::t_out  o_out_data
);

    logic        r_out_valid;
    ipv4cks_pkg::t_out r_out_data;
    logic        ready;
    logic [31:0] seg_total;

    function automatic logic [15:0] fold_invert(input logic [31:0] s);
        logic [16:0] f1;
        logic [16:0] f2;
        f1 = {1'b0, s[31:16]} + {1'b0, s[15:0]};
        f2 = f1 + {16'd0, f1[16]};
        return ~f2[15:0];
    endfunction

    assign ready     = !r_out_valid || !i_out_stall;
    assign seg_total = i_fin.segment_sum + {16'd0, i_fin.seg_len} + ipv4cks_pkg::TCP_PROTOCOL;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ready) begin
            r_out_valid <= i_fin_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready && i_fin_valid) begin
            r_out_data.ip_header_checksum <= fold_invert(i_fin.header_sum);
            r_out_data.tcp_checksum       <= fold_invert(seg_total);
            r_out_data.packet_short       <= i_fin.packet_short;
        end
    end

    assign o_fin_ready = ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;

    localparam int QUIET_LIMIT = 3000;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_BYTES = 320;
    localparam int PHASE_PACKETS = 6;

    class checksum_scoreboard;
        ipv4cks_pkg::t_out checksums_due[$];
        logic [15:0] offset;
        logic [5:0]  hdr_len;
        logic [15:0] tot_len;
        logic [31:0] hdr_sum;
        logic [31:0] seg_sum;
        int          errors;
        int          results_checked;
        int          short_flags;

        function new();
            clear_packet();
            errors = 0;
            results_checked = 0;
            short_flags = 0;
        endfunction

        function void clear_packet();
            offset = '0;
            hdr_len = '0;
            tot_len = '0;
            hdr_sum = '0;
            seg_sum = '0;
        endfunction

        function logic [15:0] fold_invert(logic [31:0] s);
            logic [31:0] t;
            t = s[31:16] + s[15:0];
            t = t + (t >> 16);
            return ~t[15:0];
        endfunction

        function void note_byte(ipv4cks_pkg::t_in x);
            logic [15:0] o;
            logic [31:0] v;
            logic [31:0] count;
            logic [31:0] seg_len;
            logic [31:0] span;
            ipv4cks_pkg::t_out r;
            o = offset;
            if (o == 16'd0) begin
                hdr_len = {x.packet_byte[3:0], 2'b00};
            end else if (o == ipv4cks_pkg::OFS_TOTLEN_HI) begin
                tot_len[15:8] = x.packet_byte;
            end else if (o == ipv4cks_pkg::OFS_TOTLEN_LO) begin
                tot_len[7:0] = x.packet_byte;
            end
            v = {24'd0, x.packet_byte};
            if (o == ipv4cks_pkg::OFS_IPCKS_HI || o == ipv4cks_pkg::OFS_IPCKS_LO) begin
                v = '0;
            end
            if (o >= hdr_len && (o - hdr_len == ipv4cks_pkg::SEG_TCPCKS_HI
                              || o - hdr_len == ipv4cks_pkg::SEG_TCPCKS_LO)) begin
                v = '0;
            end
            if (!o[0]) begin
                v = v << 8;
            end
            if (o < hdr_len) begin
                hdr_sum = hdr_sum + v;
            end
            if ((o >= hdr_len && o < tot_len)
                || (o >= ipv4cks_pkg::OFS_ADDR_FIRST && o <= ipv4cks_pkg::OFS_ADDR_LAST)) begin
                seg_sum = seg_sum + v;
            end
            if (offset != ipv4cks_pkg::OFFSET_MAX) begin
                offset = offset + 16'd1;
            end
            if (x.last_byte) begin
                count = {16'd0, o} + 32'd1;
                seg_len = (tot_len >= hdr_len) ? tot_len - hdr_len : 32'd0;
                seg_sum = seg_sum + ipv4cks_pkg::TCP_PROTOCOL + seg_len;
                span = (tot_len > hdr_len) ? tot_len : hdr_len;
                r.ip_header_checksum = fold_invert(hdr_sum);
                r.tcp_checksum = fold_invert(seg_sum);
                r.packet_short = count < span;
                checksums_due.push_back(r);
                clear_packet();
            end
        endfunction

        function void flag(string field, logic [15:0] want, logic [15:0] got);
            if (errors < 10) begin
                $display("Mismatch in %s: expected %h, got %h", field, want, got);
            end
            errors++;
        endfunction

        function void check_result(ipv4cks_pkg::t_out got);
            ipv4cks_pkg::t_out want;
            if (checksums_due.size() == 0) begin
                if (errors < 10) begin
                    $display("Result with no packet outstanding: %h", got);
                end
                errors++;
                return;
            end
            want = checksums_due.pop_front();
            results_checked++;
            if (got.packet_short) begin
                short_flags++;
            end
            if (got.ip_header_checksum !== want.ip_header_checksum) begin
                flag("ip_header_checksum", want.ip_header_checksum, got.ip_header_checksum);
            end
            if (got.tcp_checksum !== want.tcp_checksum) begin
                flag("tcp_checksum", want.tcp_checksum, got.tcp_checksum);
            end
            if (got.packet_short !== want.packet_short) begin
                flag("packet_short", 16'(want.packet_short), 16'(got.packet_short));
            end
        endfunction

        function int pending();
            return checksums_due.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    ipv4cks_pkg::t_in  in_data;
    logic out_valid;
    logic out_stall = 1'b0;
    ipv4cks_pkg::t_out out_data;

    checksum_scoreboard sb;
    logic [7:0] pkt[$];
    logic       hold_req;
    int         hold_left = 0;
    int         src_idle;
    int         stall_pct;
    int         quiet_cycles = 0;
    int         bytes_sent;
    int         packets_sent;

    ipv4_tcp_checksum_fixer uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk) begin
        if (hold_req) begin
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(negedge clk) begin
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                sb.check_result(out_data);
            end
            if (in_valid && !in_stall) begin
                sb.note_byte(in_data);
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("No transaction for %0d cycles", QUIET_LIMIT);
                $display("simulation failed");
                $finish;
            end
        end
    end

    function void build_packet(int ihl, int total, int nbytes, int fill);
        logic [15:0] tl;
        logic [7:0]  b;
        tl = 16'(total);
        pkt.delete();
        for (int i = 0; i < nbytes; i++) begin
            b = (fill < 0) ? 8'($urandom) : 8'(fill);
            if (i == 0) begin
                b = {4'h4, 4'(ihl)};
            end else if (i == ipv4cks_pkg::OFS_TOTLEN_HI) begin
                b = tl[15:8];
            end else if (i == ipv4cks_pkg::OFS_TOTLEN_LO) begin
                b = tl[7:0];
            end
            pkt.push_back(b);
        end
    endfunction

    function void build_random_packet();
        int kind;
        int ihl;
        int total;
        int nbytes;
        kind = $urandom_range(99);
        ihl = ($urandom_range(3) == 0) ? $urandom_range(15, 6) : 5;
        total = ihl * 4 + $urandom_range(40);
        nbytes = total;
        if (kind < 70) begin
            if ($urandom_range(4) == 0) begin
                nbytes = total + $urandom_range(8, 1);
            end
        end else if (kind < 80) begin
            nbytes = $urandom_range(total - 1, 1);
        end else if (kind < 88) begin
            ihl = $urandom_range(4);
            total = $urandom_range(60);
            nbytes = $urandom_range(40, 1);
        end else if (kind < 94) begin
            ihl = $urandom_range(15, 5);
            total = $urandom_range(ihl * 4 - 1);
            nbytes = ihl * 4 + $urandom_range(8);
        end
        build_packet(ihl, total, nbytes, -1);
        if (kind >= 94) begin
            foreach (pkt[i]) begin
                pkt[i] = 8'($urandom);
            end
        end
    endfunction

    task automatic send_byte(logic [7:0] b, logic last);
        ipv4cks_pkg::t_in x;
        while ($urandom_range(99) < src_idle) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        x.packet_byte = b;
        x.last_byte = last;
        in_valid <= 1'b1;
        in_data <= x;
        @(negedge clk);
        while (in_stall) begin
            @(negedge clk);
        end
        @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_packet();
        foreach (pkt[i]) begin
            send_byte(pkt[i], i == pkt.size() - 1);
        end
        packets_sent++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) begin
            @(posedge clk);
        end
    endtask

    initial begin
        int idle_cfg[4][2];
        int byte_base;
        int pkt_base;
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        hold_req = 1'b0;
        src_idle = 0;
        stall_pct = 0;
        bytes_sent = 0;
        packets_sent = 0;
        idle_cfg = '{'{0, 0}, '{60, 0}, '{0, 60}, '{25, 25}};
        sb = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        build_packet(15, 20, 1, -1);
        send_packet();
        build_packet(5, 20, 2, -1);
        send_packet();
        build_packet(5, 20, 20, -1);
        send_packet();
        build_packet(15, 60, 60, 255);
        send_packet();
        build_packet(5, 40, 40, 255);
        send_packet();
        build_packet(0, 0, 40, 0);
        send_packet();
        build_packet(0, 30, 30, -1);
        send_packet();
        build_packet(3, 10, 24, -1);
        send_packet();
        build_packet(10, 20, 40, -1);
        send_packet();
        build_packet(5, 41, 41, -1);
        send_packet();
        build_packet(5, 100, 50, -1);
        send_packet();
        build_packet(5, 46, 60, -1);
        send_packet();
        build_packet(5, 65535, 24, -1);
        send_packet();
        build_packet(5, 0, 20, -1);
        send_packet();

        byte_base = bytes_sent;
        pkt_base = packets_sent;
        for (int ph = 0; ph < 4; ph++) begin
            src_idle = idle_cfg[ph][0];
            stall_pct = idle_cfg[ph][1];
            while (bytes_sent - byte_base < PHASE_BYTES * (ph + 1) ||
                   packets_sent - pkt_base < PHASE_PACKETS * (ph + 1)) begin
                build_random_packet();
                send_packet();
            end
        end

        src_idle = 0;
        stall_pct = 0;
        drain_results();
        @(negedge clk);
        hold_req = 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
        for (int k = 0; k < 6; k++) begin
            build_packet(5, 20 + $urandom_range(10), 20 + $urandom_range(10), -1);
            send_packet();
        end
        drain_results();
        repeat (4) @(posedge clk);

        $display("Sent %0d packets in %0d bytes, checked %0d results (%0d flagged short).",
                 packets_sent, bytes_sent, sb.results_checked, sb.short_flags);
        $display("Exercised odd header lengths, padding, noise and a long receiver hold-off.");
        if (sb.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d mismatches", sb.errors);
            $display("simulation failed");
        end
        $finish;
    end
endmodule
